@@ hw/rtl/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;

  localparam int PH_W = 26;
  localparam logic [25:0] PH_ONE = 26'd16777216;
  localparam logic [25:0] PH_TWO = 26'd33554432;
  localparam int ANG_PI = 205887;

  localparam logic [2:0] REG_P0 = 3'd0;
  localparam logic [2:0] REG_P1 = 3'd1;
  localparam logic [2:0] REG_P2 = 3'd2;
  localparam logic [2:0] REG_P3 = 3'd3;
  localparam logic [2:0] REG_SPEED = 3'd4;
  localparam logic [2:0] REG_LOOP = 3'd5;
  localparam logic [2:0] REG_EASE = 3'd6;

  localparam logic [1:0] LOOP_WRAP = 2'd0;
  localparam logic [1:0] LOOP_PINGPONG = 2'd1;
  localparam logic [1:0] LOOP_ONCE_ZERO = 2'd2;
  localparam logic [1:0] LOOP_ONCE_HOLD = 2'd3;

  localparam logic [2:0] EASE_IN = 3'd1;
  localparam logic [2:0] EASE_OUT = 3'd2;
  localparam logic [2:0] EASE_INOUT = 3'd3;
  localparam logic [2:0] EASE_SMOOTH = 3'd4;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PHASE, OP_EASE1, OP_EASE2, OP_WEIGHT1, OP_WEIGHT2,
    OP_WEIGHT3, OP_POS, OP_DER, OP_CORDIC_INIT, OP_CORDIC_STEP, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic [4:0] idx;
  } dp_cmd_t;

  function automatic logic signed [18:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 19'sd51472;
      5'd1: atan_q16 = 19'sd30386;
      5'd2: atan_q16 = 19'sd16055;
      5'd3: atan_q16 = 19'sd8150;
      5'd4: atan_q16 = 19'sd4091;
      5'd5: atan_q16 = 19'sd2047;
      5'd6: atan_q16 = 19'sd1024;
      5'd7: atan_q16 = 19'sd512;
      5'd8: atan_q16 = 19'sd256;
      5'd9: atan_q16 = 19'sd128;
      5'd10: atan_q16 = 19'sd64;
      5'd11: atan_q16 = 19'sd32;
      5'd12: atan_q16 = 19'sd16;
      5'd13: atan_q16 = 19'sd8;
      5'd14: atan_q16 = 19'sd4;
      5'd15: atan_q16 = 19'sd2;
      5'd16: atan_q16 = 19'sd1;
      default: atan_q16 = 19'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bpa_ctrl.sv @@
`default_nettype none
module bpa_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output bpa_pkg::dp_cmd_t     cmd
);
  import bpa_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PHASE = 4'd1;
  localparam logic [3:0] S_E1 = 4'd2;
  localparam logic [3:0] S_E2 = 4'd3;
  localparam logic [3:0] S_W1 = 4'd4;
  localparam logic [3:0] S_W2 = 4'd5;
  localparam logic [3:0] S_W3 = 4'd6;
  localparam logic [3:0] S_POS = 4'd7;
  localparam logic [3:0] S_DER = 4'd8;
  localparam logic [3:0] S_CI = 4'd9;
  localparam logic [3:0] S_CS = 4'd10;
  localparam logic [3:0] S_FIN = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd.op = OP_NONE;
    cmd.idx = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = OP_LOAD;
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin cmd.op = OP_PHASE; state_nxt = S_E1; end
      S_E1: begin cmd.op = OP_EASE1; state_nxt = S_E2; end
      S_E2: begin cmd.op = OP_EASE2; state_nxt = S_W1; end
      S_W1: begin cmd.op = OP_WEIGHT1; state_nxt = S_W2; end
      S_W2: begin cmd.op = OP_WEIGHT2; state_nxt = S_W3; end
      S_W3: begin cmd.op = OP_WEIGHT3; cnt_nxt = '0; state_nxt = S_POS; end
      S_POS: begin
        cmd.op = OP_POS;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          cnt_nxt = '0;
          state_nxt = S_DER;
        end
      end
      S_DER: begin
        cmd.op = OP_DER;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) state_nxt = S_CI;
      end
      S_CI: begin cmd.op = OP_CORDIC_INIT; cnt_nxt = '0; state_nxt = S_CS; end
      S_CS: begin
        cmd.op = OP_CORDIC_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(NSTEP - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin cmd.op = OP_FINISH; state_nxt = S_OUT; end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bpa_datapath.sv @@
`default_nettype none
module bpa_datapath #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpa_pkg::dp_cmd_t   cmd,
  input  wire logic               cfg_tvalid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [39:0]        cfg_data,
  input  wire logic signed [31:0] ext_phase,
  input  wire logic               trigger,
  input  wire logic [24:0]        frame_dt,
  output logic signed [18:0]      x_position,
  output logic signed [18:0]      y_position,
  output logic signed [18:0]      tangent_angle,
  output logic [24:0]             progress
);
  import bpa_pkg::*;

  localparam logic signed [63:0] LIM_RAW = 64'sd2 <<< COORD_FRAC_BITS;
  localparam logic signed [63:0] LIM = (LIM_RAW > 64'sd262143) ? 64'sd262143 : LIM_RAW;
  localparam logic signed [27:0] ONE = 28'sd16777216;

  logic [39:0] pt_r [4];
  logic [20:0] speed_r;
  logic [1:0]  loop_r;
  logic [2:0]  ease_r;
  logic [25:0] free_r;

  logic signed [32:0] raw_r;
  logic [24:0] t_r;
  logic signed [27:0] e_r, sq_r;
  logic signed [27:0] uu_r, ee_r, ue_r;
  logic signed [27:0] w_r [4];
  logic signed [63:0] accx_r, accy_r, dx_r, dy_r;
  logic signed [47:0] cx_r, cy_r;
  logic signed [23:0] z_r;

  function automatic logic signed [27:0] m24(input logic signed [27:0] a,
                                             input logic signed [27:0] b);
    logic signed [55:0] p;
    p = a * b;
    m24 = 28'(p >>> 24);
  endfunction

  function automatic logic signed [19:0] px(input logic [39:0] p);
    px = p[19:0];
  endfunction
  function automatic logic signed [19:0] py(input logic [39:0] p);
    py = p[39:20];
  endfunction

  logic signed [27:0] t28, u28;
  logic [31:0] s_full;
  logic [25:0] s_sum;
  logic [46:0] inc;
  logic [24:0] t_fold;
  logic signed [27:0] coef;
  logic signed [20:0] dpx, dpy;
  logic [1:0] k0, k1;

  assign t28 = 28'(t_r);
  assign u28 = ONE - e_r;

  always_comb begin
    inc = 47'(frame_dt) * 47'(speed_r);
    s_full = 32'(trigger ? 26'd0 : free_r) + 32'(inc[46:16]);
    if (loop_r == LOOP_WRAP || loop_r == LOOP_PINGPONG) s_sum = {1'b0, s_full[24:0]};
    else if (s_full > 32'(PH_TWO)) s_sum = PH_TWO;
    else s_sum = s_full[25:0];
    t_fold = '0;
    case (loop_r)
      LOOP_WRAP: t_fold = {1'b0, raw_r[23:0]};
      LOOP_PINGPONG:
        t_fold = (raw_r[24:0] > PH_ONE[24:0]) ? 25'(PH_TWO - 26'(raw_r[24:0]))
                                              : raw_r[24:0];
      LOOP_ONCE_ZERO:
        t_fold = (raw_r >= 33'sd16777216 || raw_r < 0) ? '0 : raw_r[24:0];
      default:
        t_fold = (raw_r < 0) ? '0 : ((raw_r > 33'sd16777216) ? PH_ONE[24:0]
                                                              : raw_r[24:0]);
    endcase
    k0 = cmd.idx[1:0];
    k1 = 2'(cmd.idx[1:0] + 2'd1);
    coef = (cmd.idx[1:0] == 2'd0) ? 28'sd3 * uu_r :
           (cmd.idx[1:0] == 2'd1) ? 28'sd6 * ue_r : 28'sd3 * ee_r;
    dpx = 21'(px(pt_r[k1])) - 21'(px(pt_r[k0]));
    dpy = 21'(py(pt_r[k1])) - 21'(py(pt_r[k0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r[0] <= 40'd0;
      pt_r[1] <= 40'd34359758438;
      pt_r[2] <= 40'd34359784653;
      pt_r[3] <= 40'd65536;
      speed_r <= 21'd65536;
      loop_r <= LOOP_WRAP;
      ease_r <= '0;
      free_r <= '0;
    end else begin
      if (cfg_tvalid) begin
        case (cfg_index)
          REG_P0: pt_r[0] <= cfg_data;
          REG_P1: pt_r[1] <= cfg_data;
          REG_P2: pt_r[2] <= cfg_data;
          REG_P3: pt_r[3] <= cfg_data;
          REG_SPEED: speed_r <= cfg_data[20:0];
          REG_LOOP: loop_r <= cfg_data[1:0];
          REG_EASE: ease_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        if (ext_phase != 0) begin
          raw_r <= 33'(ext_phase);
          if (trigger) free_r <= '0;
        end else begin
          free_r <= s_sum;
          raw_r <= 33'(s_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PHASE: t_r <= t_fold;
      OP_EASE1: begin
        sq_r <= m24(t28, t28);
        case (ease_r)
          EASE_OUT: e_r <= m24(t28, 28'sd33554432 - t28);
          EASE_INOUT: e_r <= m24(28'sd67108864 - 28'sd2 * t28, t28) - ONE;
          default: e_r <= t28;
        endcase
      end
      OP_EASE2: begin
        case (ease_r)
          EASE_IN: e_r <= sq_r;
          EASE_INOUT: if (t28 < 28'sd8388608) e_r <= 28'sd2 * sq_r;
          EASE_SMOOTH: e_r <= m24(sq_r, 28'sd50331648 - 28'sd2 * t28);
          default: ;
        endcase
      end
      OP_WEIGHT1: begin
        uu_r <= m24(u28, u28);
        ee_r <= m24(e_r, e_r);
        ue_r <= m24(u28, e_r);
      end
      OP_WEIGHT2: begin
        w_r[0] <= m24(uu_r, u28);
        w_r[1] <= 28'sd3 * m24(uu_r, e_r);
      end
      OP_WEIGHT3: begin
        w_r[2] <= 28'sd3 * m24(u28, ee_r);
        w_r[3] <= m24(ee_r, e_r);
        accx_r <= '0;
        accy_r <= '0;
        dx_r <= '0;
        dy_r <= '0;
      end
      OP_POS: begin
        accx_r <= accx_r + 64'(w_r[cmd.idx[1:0]]) * 64'(px(pt_r[cmd.idx[1:0]]));
        accy_r <= accy_r + 64'(w_r[cmd.idx[1:0]]) * 64'(py(pt_r[cmd.idx[1:0]]));
      end
      OP_DER: begin
        dx_r <= dx_r + 64'(coef) * 64'(dpx);
        dy_r <= dy_r + 64'(coef) * 64'(dpy);
      end
      OP_CORDIC_INIT: begin
        if (dx_r < 0) begin
          cx_r <= 48'(-dx_r);
          cy_r <= 48'(-dy_r);
          z_r <= (dy_r >= 0) ? 24'sd205887 : -24'sd205887;
        end else begin
          cx_r <= 48'(dx_r);
          cy_r <= 48'(dy_r);
          z_r <= '0;
        end
      end
      OP_CORDIC_STEP: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + 48'(cy_r >>> cmd.idx);
          cy_r <= cy_r - 48'(cx_r >>> cmd.idx);
          z_r <= z_r + 24'(atan_q16(cmd.idx));
        end else begin
          cx_r <= cx_r - 48'(cy_r >>> cmd.idx);
          cy_r <= cy_r + 48'(cx_r >>> cmd.idx);
          z_r <= z_r - 24'(atan_q16(cmd.idx));
        end
      end
      OP_FINISH: begin
        progress <= t_r;
        x_position <= 19'((accx_r >>> 24) > LIM ? LIM :
                          ((accx_r >>> 24) < -LIM ? -LIM : (accx_r >>> 24)));
        y_position <= 19'((accy_r >>> 24) > LIM ? LIM :
                          ((accy_r >>> 24) < -LIM ? -LIM : (accy_r >>> 24)));
        if (dx_r == 0 && dy_r == 0) tangent_angle <= '0;
        else if (z_r > 24'sd205887) tangent_angle <= 19'sd205887;
        else if (z_r < -24'sd205887) tangent_angle <= -19'sd205887;
        else tangent_angle <= 19'(z_r);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/bezier_path_animator.sv @@
`default_nettype none
// Cubic Bezier path animator. Each input transfer (external phase, trigger,
// frame time) yields one output transfer (x, y, tangent angle, progress).
// One item at a time: a new input is taken only after the previous result
// has been taken at the output. The result is produced by the shared multiply
// sequence followed by the iterative CORDIC.
// Configuration writes go through cfg_*; the user must write only while no
// item is in flight, since the block itself does not enforce this.
module bezier_path_animator #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [39:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // phase[31:0], frame time[56:32]
  input  wire logic        in_tuser,   // trigger
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata   // x[18:0], y[37:19], angle[56:38], progress[81:57]
);
  import bpa_pkg::*;

  dp_cmd_t cmd;
  logic signed [18:0] xp, yp, ang;
  logic [24:0] prog;

  assign cfg_ready = 1'b1;
  assign out_tdata = {6'd0, prog, ang, yp, xp};

  bpa_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd
  );

  bpa_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .cfg_tvalid(cfg_valid), .cfg_index, .cfg_data,
    .ext_phase(in_tdata[31:0]), .trigger(in_tuser), .frame_dt(in_tdata[56:32]),
    .x_position(xp), .y_position(yp), .tangent_angle(ang), .progress(prog)
  );

  logic unused_in;
  assign unused_in = ^in_tdata[63:57];
endmodule
`default_nettype wire
